// ===== hw/rtl/lgfs_pkg.sv =====
// Package for the lidar gap-follow steering block.
// Holds the scan store sizing, the payload structs, the register map and the sequencer states.
// No dependencies.
package lgfs_pkg;

	localparam int MAX_SAMPLES = 2048;
	localparam int AW = $clog2(MAX_SAMPLES);        // store address width
	localparam int CW = $clog2(MAX_SAMPLES + 1);    // sample count width
	localparam int WW = (CW > 11) ? CW : 11;        // window arithmetic width
	localparam int BW = AW + 10;                    // signed bubble bound width
	localparam int PW = CW + 16;                    // midpoint times step
	localparam int ANG_W = PW + 2;                  // signed angle before clamping

	localparam logic [15:0] GAP_THRESHOLD_RST = 16'd1600;
	localparam logic [9:0] EDGE_SKIP_RST = 10'd340;
	localparam logic [7:0] BUBBLE_HALF_RST = 8'd15;
	localparam logic signed [19:0] ANGLE_START_RST = -20'sd154415;
	localparam logic [15:0] ANGLE_STEP_RST = 16'd285;
	localparam logic [16:0] STEER_LIMIT_RST = 17'd25164;
	localparam logic [16:0] SLOW_ANGLE_RST = 17'd11438;

	localparam logic [1:0] SPEED_FAST = 2'd3;
	localparam logic [1:0] SPEED_SLOW = 2'd2;

	typedef enum logic [2:0] {
		CFG_GAP_THRESHOLD = 3'd0,
		CFG_EDGE_SKIP = 3'd1,
		CFG_BUBBLE_HALF = 3'd2,
		CFG_ANGLE_START = 3'd3,
		CFG_ANGLE_STEP = 3'd4,
		CFG_STEER_LIMIT = 3'd5,
		CFG_SLOW_ANGLE = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIN,
		S_RUN,
		S_MUL,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [15:0] range_sample;
		logic sample_valid;
		logic scan_last;
	} in_item_t;

	typedef struct packed {
		logic signed [17:0] steer_angle;
		logic [1:0] drive_speed;
		logic [10:0] gap_first;
		logic [11:0] gap_size;
	} out_item_t;

endpackage

// ===== hw/rtl/lidar_gap_follow_steering.sv =====
// Top level of the lidar gap-follow steering block: scan store, search sequencer and steering math.
// Depends on lgfs_pkg.
//
// Usage: range samples of one scan arrive as beats on the in channel, one per cycle while the
// block is idle. A beat with an invalid reading is stored as zero; samples past the store depth
// are dropped, but a dropped beat with scan_last still ends the scan. Every beat with scan_last
// yields exactly one beat on the out channel, none otherwise.
// After the last sample the block runs two passes over the search window (edge_skip samples cut
// from each end, W entries): a nearest-sample search, then a longest-free-run search in which the
// zeroed bubble around the nearest sample is applied on the fly. Each pass reads one store entry
// a cycle through the single read port. A multiply step and a finish step follow; an empty window
// skips both passes and goes straight to the multiply step.
// in_ready is low from the last sample until the result is placed in the output register.
// The result waits in that register while out_ready is low, and the block takes the next scan
// meanwhile; if that scan finishes first, the block holds in its finish step and takes no new
// samples until the old beat is taken.
// Configuration writes are always accepted (cfg_ready is high); the user must make them only while
// idle; the block does not enforce it. Reset clears the sample count, the output valid and restores
// all register defaults; the store needs no clearing since only this scan's entries are read.
module lidar_gap_follow_steering (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lgfs_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output lgfs_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [19:0] cfg_data
);
	import lgfs_pkg::*;

	// Configuration registers.
	logic [15:0] gap_threshold_q;
	logic [9:0] edge_skip_q;
	logic [7:0] bubble_half_q;
	logic signed [19:0] angle_start_q;
	logic [15:0] angle_step_q;
	logic [16:0] steer_limit_q;
	logic [16:0] slow_angle_q;

	// Sequencer and store.
	state_t state_q, state_d;
	logic [15:0] range_store [MAX_SAMPLES];
	logic [CW-1:0] count_q;
	logic [CW-1:0] addr_q;
	logic [CW-1:0] hi_q;
	logic [15:0] rd_data_s1;
	logic [AW-1:0] idx_s1;
	logic rd_vld_s1;

	// Search results.
	logic [15:0] near_val_q;
	logic [AW-1:0] near_idx_q;
	logic signed [BW-1:0] b0_q, b1_q;
	logic [AW-1:0] run_first_q, best_first_q;
	logic [CW-1:0] run_size_q, best_size_q;
	logic [PW-1:0] prod_q;
	logic out_valid_q;
	out_item_t out_q;

	// Control from the sequencer.
	logic in_acc;
	logic issue;
	logic pass_done;
	logic load_out;

	// Window bounds for the scan that ends with this beat.
	logic [CW-1:0] n_w;
	logic [WW-1:0] n_x, skip_x, hi_x;
	logic win_ok;

	// Datapath terms.
	logic in_bubble;
	logic free_s1;
	logic [CW-1:0] run_size_n;
	logic [CW:0] half_up;
	logic [CW-1:0] mid;
	logic signed [ANG_W-1:0] angle, lim, clamped;
	logic [17:0] mag;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		n_w = count_q + CW'(count_q < CW'(MAX_SAMPLES));
		n_x = WW'(n_w);
		skip_x = WW'(edge_skip_q);
		hi_x = (n_x > (WW'(edge_skip_q) << 1)) ? n_x - skip_x : skip_x;
		win_ok = hi_x > skip_x;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_data.scan_last) begin
					state_d = win_ok ? S_MIN : S_MUL;
				end
			end
			S_MIN: begin
				if (pass_done) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (pass_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: state_d = S_FIN;
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		issue = 1'b0;
		pass_done = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_MIN, S_RUN: begin
				issue = addr_q < hi_q;
				pass_done = !(addr_q < hi_q) && !rd_vld_s1;
			end
			S_FIN: load_out = !out_valid_q || out_ready;
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// Run tracking and steering math.
	always_comb begin
		in_bubble = ($signed(BW'(idx_s1)) >= b0_q) && ($signed(BW'(idx_s1)) < b1_q);
		free_s1 = (in_bubble ? 16'd0 : rd_data_s1) >= gap_threshold_q;
		run_size_n = run_size_q + CW'(1);
		half_up = ((CW+1)'(best_size_q) + (CW+1)'(1)) >> 1;
		mid = CW'(best_first_q) + half_up[CW-1:0];
		angle = ANG_W'(angle_start_q) + $signed(ANG_W'(prod_q));
		lim = $signed(ANG_W'(steer_limit_q));
		if (angle >= lim) begin
			clamped = lim;
		end else if (angle <= -lim) begin
			clamped = -lim;
		end else begin
			clamped = angle;
		end
		mag = clamped[ANG_W-1] ? 18'(-clamped) : 18'(clamped);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_threshold_q <= GAP_THRESHOLD_RST;
			edge_skip_q <= EDGE_SKIP_RST;
			bubble_half_q <= BUBBLE_HALF_RST;
			angle_start_q <= ANGLE_START_RST;
			angle_step_q <= ANGLE_STEP_RST;
			steer_limit_q <= STEER_LIMIT_RST;
			slow_angle_q <= SLOW_ANGLE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_GAP_THRESHOLD: gap_threshold_q <= cfg_data[15:0];
				CFG_EDGE_SKIP: edge_skip_q <= cfg_data[9:0];
				CFG_BUBBLE_HALF: bubble_half_q <= cfg_data[7:0];
				CFG_ANGLE_START: angle_start_q <= $signed(cfg_data);
				CFG_ANGLE_STEP: angle_step_q <= cfg_data[15:0];
				CFG_STEER_LIMIT: steer_limit_q <= cfg_data[16:0];
				CFG_SLOW_ANGLE: slow_angle_q <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= issue;
			if (in_acc) begin
				count_q <= in_data.scan_last ? '0 : n_w;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan store: one write port for loading, one registered read port for the passes.
	always_ff @(posedge clk) begin
		if (in_acc && (count_q < CW'(MAX_SAMPLES))) begin
			range_store[count_q[AW-1:0]] <= in_data.sample_valid ? in_data.range_sample : 16'd0;
		end
		rd_data_s1 <= range_store[addr_q[AW-1:0]];
		idx_s1 <= addr_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.scan_last) begin
			addr_q <= CW'(skip_x);
			hi_q <= CW'(hi_x);
			near_val_q <= 16'hFFFF;
			near_idx_q <= AW'(skip_x);
			best_first_q <= '0;
			best_size_q <= '0;
		end else if (issue) begin
			addr_q <= addr_q + CW'(1);
		end

		if (state_q == S_MIN) begin
			// Strict compare keeps the first of equal minima.
			if (rd_vld_s1 && (rd_data_s1 < near_val_q)) begin
				near_val_q <= rd_data_s1;
				near_idx_q <= idx_s1;
			end
			if (pass_done) begin
				addr_q <= CW'(skip_x);
				b0_q <= $signed(BW'(near_idx_q)) - $signed(BW'(bubble_half_q));
				b1_q <= $signed(BW'(near_idx_q)) + $signed(BW'(bubble_half_q));
				run_size_q <= '0;
			end
		end

		if ((state_q == S_RUN) && rd_vld_s1) begin
			if (free_s1) begin
				run_size_q <= run_size_n;
				if (run_size_q == '0) begin
					run_first_q <= idx_s1;
				end
				// Strict compare keeps the first of equally long runs.
				if (run_size_n > best_size_q) begin
					best_size_q <= run_size_n;
					best_first_q <= (run_size_q == '0) ? idx_s1 : run_first_q;
				end
			end else begin
				run_size_q <= '0;
			end
		end

		if (state_q == S_MUL) begin
			prod_q <= PW'(mid) * PW'(angle_step_q);
		end

		if (load_out) begin
			out_q.steer_angle <= clamped[17:0];
			out_q.drive_speed <= ({1'b0, slow_angle_q} >= mag) ? SPEED_FAST : SPEED_SLOW;
			out_q.gap_first <= 11'(best_first_q);
			out_q.gap_size <= 12'(best_size_q);
		end
	end

	// A read is only in flight during one of the two search passes.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_MIN || state_q == S_RUN))
		else $error("store read outside a search pass");

	// The sample count is cleared whenever a scan is being searched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (count_q == '0))
		else $error("sample count not cleared after last sample");

	// The count never passes the store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	// A new result only appears out of the finish step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result raised outside finish step");

endmodule
